// File: sv/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Types, constants and helpers shared by the bit stream packer modules.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int FIELD_W = 64;
  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 3;
  localparam int STEP_W  = 4;   // holds a chunk size of 0 to 8 bits

  typedef struct packed {
    logic [FIELD_W-1:0] field_value;
    logic [LEN_W-1:0]   field_length;
    logic               msb_first;
    logic               finish;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_run;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic close;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic slot_free;
  } status_t;

  // low n bits set, n in 0..8
  function automatic logic [BYTE_W-1:0] low_mask(input logic [STEP_W-1:0] n);
    logic [BYTE_W:0] t;
    t = (9'd1 << n) - 9'd1;
    return t[BYTE_W-1:0];
  endfunction

  // top n bits set, n in 0..8
  function automatic logic [BYTE_W-1:0] top_mask(input logic [STEP_W-1:0] n);
    return ~(8'hFF >> n);
  endfunction

endpackage

// File: sv/bsp_in_if.sv
// ----------------------------------------------------------------------------
// bsp_in_if
// Input item channel: valid, ready and one item per beat.
// ----------------------------------------------------------------------------
interface bsp_in_if
  import bsp_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/bsp_out_if.sv
// ----------------------------------------------------------------------------
// bsp_out_if
// Output byte channel: valid, ready and one packed byte per beat.
// ----------------------------------------------------------------------------
interface bsp_out_if
  import bsp_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/bsp_datapath.sv
// ----------------------------------------------------------------------------
// bsp_datapath
// Field shifter, partial byte, bit count and output register of the packer.
// ----------------------------------------------------------------------------
module bsp_datapath
  import bsp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  item_t         item,
  input  cmd_t          cmd,
  output status_t       status,
  bsp_out_if.source     byte_out
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD_BITS);

  logic [FIELD_W-1:0] sreg;
  logic [LEN_W-1:0]   rem;
  logic               msb;
  logic               fin;
  logic [BYTE_W-1:0]  pend;
  logic [CNT_W-1:0]   cnt;
  logic               out_valid;
  result_t            out_data;

  logic [LEN_W-1:0]   len_sat;
  logic [LEN_W-1:0]   lsh;
  logic [STEP_W-1:0]  avail;
  logic [STEP_W-1:0]  n;
  logic [STEP_W-1:0]  cnt_sum;
  logic [BYTE_W-1:0]  chunk;
  logic [BYTE_W-1:0]  pend_new;
  logic [LEN_W-1:0]   rem_after;
  logic               full;
  logic               flush_emit;
  logic               emit;

  assign len_sat = (item.field_length > MAX_LEN) ? MAX_LEN : item.field_length;
  // left-justify in msb mode so the next bit always sits at the top
  assign lsh     = LEN_W'(FIELD_W) - len_sat;

  assign avail   = STEP_W'(BYTE_W) - {1'b0, cnt};
  assign n       = ({{(LEN_W-STEP_W){1'b0}}, avail} > rem) ? rem[STEP_W-1:0] : avail;
  assign cnt_sum = {1'b0, cnt} + n;
  assign full    = cnt_sum[CNT_W];
  assign rem_after = rem - {{(LEN_W-STEP_W){1'b0}}, n};

  always_comb begin
    if (msb) begin
      chunk = (sreg[FIELD_W-1 -: BYTE_W] & top_mask(n)) >> cnt;
    end else begin
      chunk = BYTE_W'({8'h00, sreg[BYTE_W-1:0] & low_mask(n)} << cnt);
    end
    pend_new = pend | chunk;
  end

  assign flush_emit = cmd.close && fin && (cnt != '0);
  assign emit       = (cmd.step && full) || flush_emit;

  assign status.rem_zero  = (rem == '0);
  assign status.slot_free = !out_valid || byte_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.step) begin
        cnt  <= cnt_sum[CNT_W-1:0];
        pend <= full ? '0 : pend_new;
      end else if (cmd.close && fin) begin
        cnt  <= '0;
        pend <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sreg <= item.msb_first ? (item.field_value << lsh) : item.field_value;
      rem  <= len_sat;
      msb  <= item.msb_first;
      fin  <= item.finish;
    end else if (cmd.step) begin
      sreg <= msb ? (sreg << n) : (sreg >> n);
      rem  <= rem_after;
    end
    if (cmd.step && full) begin
      out_data.data_byte   <= pend_new;
      // last unless a further full byte or a flushed tail byte follows
      out_data.last_of_run <= (rem_after == '0) || ((rem_after < LEN_W'(BYTE_W)) && !fin);
    end else if (flush_emit) begin
      out_data.data_byte   <= pend;
      out_data.last_of_run <= 1'b1;
    end
  end

  assign byte_out.valid = out_valid;
  assign byte_out.data  = out_data;

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.close}))
    else $error("more than one datapath command at once");

  a_step_has_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (rem != '0))
    else $error("step issued with no bits left");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> status.slot_free)
    else $error("byte emitted over an untaken beat");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.close && fin) |=> (cnt == '0 && pend == '0))
    else $error("finish left a partial byte behind");

endmodule

// File: sv/bsp_ctrl.sv
// ----------------------------------------------------------------------------
// bsp_ctrl
// Sequencer: takes an item, steps the datapath a chunk at a time, closes.
// ----------------------------------------------------------------------------
module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // advance only while the output slot can take a byte
        if (status.slot_free) begin
          if (!status.rem_zero) begin
            cmd.step = 1'b1;
          end else begin
            cmd.close  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_ready)
    else $error("load outside idle");

  a_run_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_RUN))
    else $error("no run after load");

  a_close_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> in_ready)
    else $error("not idle after close");

endmodule

// File: sv/bit_stream_packer_top.sv
// ----------------------------------------------------------------------------
// bit_stream_packer_top
// Appends 0 to 64 bit fields, lsb or msb first, to a byte stream.
// ----------------------------------------------------------------------------
//  channel    dir  beat
//  item_in    in   field_value[64], field_length[7], msb_first, finish
//  byte_out   out  data_byte[8], last_of_run
//
//  An item is loaded, then stepped through the chunks (bits up to the next
//  byte boundary, at most eight each) that the field splits into, then
//  closed; a new item is taken only after the close. The datapath shifter
//  steps one chunk per cycle while the output slot can take a byte.
//  Reset (rst, synchronous) clears the partial byte, its count and the
//  output beat. A stalled output holds the sequencer between steps.
// ----------------------------------------------------------------------------
module bit_stream_packer_top
  import bsp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  bsp_in_if.sink     item_in,
  bsp_out_if.source  byte_out
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign item_in.ready = in_ready;

  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bsp_datapath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item_in.data),
    .cmd      (cmd),
    .status   (status),
    .byte_out (byte_out)
  );

endmodule

// File: tb/sv/bit_stream_packer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_stream_packer_checker
// Watches the item and byte channels of the bit stream packer, packs every
// accepted field into its own partial byte and compares each output beat
// with the oldest predicted byte.
// ----------------------------------------------------------------------------
module bit_stream_packer_checker
  import bsp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  bsp_in_if    item_in,
  bsp_out_if   byte_out,
  output int   mismatches,
  output int   bytes_due
);

  result_t           byte_queue[$];
  logic [BYTE_W-1:0] part_byte;
  int                part_bits;
  int                fail_cnt;

  // Append the field bit by bit, then flush a partial byte when asked to.
  function automatic void append_field(input item_t it);
    int unsigned       n;
    int unsigned       idx;
    logic [BYTE_W-1:0] done[$];
    result_t           r;
    n = it.field_length;
    if (n > MAX_FIELD_BITS) n = MAX_FIELD_BITS;
    for (int unsigned i = 0; i < n; i++) begin
      idx = it.msb_first ? n - 1 - i : i;
      if (it.field_value[idx]) begin
        if (it.msb_first) part_byte[7 - part_bits] = 1'b1;
        else part_byte[part_bits] = 1'b1;
      end
      part_bits++;
      if (part_bits == 8) begin
        done.insert(done.size(), part_byte);
        part_byte = '0;
        part_bits = 0;
      end
    end
    if (it.finish) begin
      if (part_bits != 0) done.insert(done.size(), part_byte);
      part_byte = '0;
      part_bits = 0;
    end
    foreach (done[k]) begin
      r.data_byte   = done[k];
      r.last_of_run = (k == done.size() - 1);
      byte_queue.insert(byte_queue.size(), r);
    end
  endfunction

  function automatic void check_byte(input result_t got);
    result_t want;
    if (byte_queue.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: byte %02h (last %0b) with none expected",
                 $time, got.data_byte, got.last_of_run);
      return;
    end
    want = byte_queue.pop_front();
    if (got.data_byte !== want.data_byte || got.last_of_run !== want.last_of_run) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                 $time, want.data_byte, want.last_of_run, got.data_byte, got.last_of_run);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      byte_queue.delete();
      part_byte = '0;
      part_bits = 0;
    end else begin
      if (item_in.valid && item_in.ready) append_field(item_in.data);
      if (byte_out.valid && byte_out.ready) check_byte(byte_out.data);
    end
    mismatches <= fail_cnt;
    bytes_due  <= byte_queue.size();
  end

endmodule

// File: tb/sv/bit_stream_packer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_stream_packer_top_tb
// Drives directed and random fields, in both bit orders and with flushes,
// into the bit stream packer under bursty input and a stalling byte sink.
// The checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module bit_stream_packer_top_tb;
  import bsp_pkg::*;

  localparam int N_RANDOM   = 330;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  int   mismatches;
  int   bytes_due;
  int   burst_left;
  int   idle_cycles;
  int   stall_mode;
  int   mode_left;
  int   cycle_cnt;

  bsp_in_if  item_in ();
  bsp_out_if byte_out ();

  bit_stream_packer_top #(.MAX_FIELD_BITS(64)) DUT (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .byte_out (byte_out)
  );

  bit_stream_packer_checker #(.MAX_FIELD_BITS(64)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .byte_out   (byte_out),
    .mismatches (mismatches),
    .bytes_due  (bytes_due)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic item_t make_item(input logic [FIELD_W-1:0] value, input int len,
                                      input logic msb, input logic fin);
    item_t it;
    it.field_value  = value;
    it.field_length = LEN_W'(len);
    it.msb_first    = msb;
    it.finish       = fin;
    return it;
  endfunction

  // Mostly short fields, a fair share of long and over-long ones.
  function automatic item_t rand_field();
    item_t it;
    int    sel;
    int    len;
    sel = $urandom_range(0, 99);
    if (sel < 45) len = $urandom_range(1, 8);
    else if (sel < 75) len = $urandom_range(9, 63);
    else if (sel < 83) len = 64;
    else if (sel < 93) len = $urandom_range(65, 127);
    else len = 0;
    it.field_value  = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel == 0) it.field_value = '0;
    else if (sel == 1) it.field_value = '1;
    it.field_length = LEN_W'(len);
    it.msb_first    = 1'($urandom_range(0, 1));
    it.finish       = (len == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
    return it;
  endfunction

  // Hold the beat until accepted; close a burst with a random gap.
  task automatic push_item(input item_t it);
    item_in.data  <= it;
    item_in.valid <= 1'b1;
    do @(posedge clk); while (!item_in.ready);
    if (burst_left == 0) begin
      item_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    item_in.valid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
  endtask

  // Byte sink: free-running, random, mostly stalled or periodic stretches.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: byte_out.ready <= 1'b1;
      1: byte_out.ready <= ($urandom_range(0, 1) == 1);
      2: byte_out.ready <= ($urandom_range(0, 4) == 0);
      default: byte_out.ready <= (cycle_cnt[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (byte_out.valid && byte_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            <= 1'b1;
    item_in.valid  <= 1'b0;
    item_in.data   <= '0;
    burst_left     = $urandom_range(1, 24);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty field, then a flush with nothing pending
    push_item(make_item(64'h0, 0, 1'b0, 1'b0));
    push_item(make_item(64'h0, 0, 1'b1, 1'b1));
    push_item(make_item('1, 64, 1'b0, 1'b0));
    push_item(make_item(64'hA5C3_0F96_1234_8001, 64, 1'b1, 1'b0));
    push_item(make_item(64'h0, 64, 1'b1, 1'b0));
    // over-long lengths saturate
    push_item(make_item(64'hFEDC_BA98_7654_3210, 127, 1'b0, 1'b0));
    push_item(make_item(64'h8000_0000_0000_0001, 65, 1'b1, 1'b0));
    // mix both orders in one partial byte, then flush it
    push_item(make_item(64'h5, 3, 1'b0, 1'b0));
    push_item(make_item(64'h3, 2, 1'b1, 1'b0));
    push_item(make_item(64'h1, 1, 1'b0, 1'b1));
    // bits above the length are dropped; flush by an empty field
    push_item(make_item('1, 5, 1'b0, 1'b0));
    push_item(make_item(64'h0, 0, 1'b0, 1'b1));
    push_item(make_item(64'h6B, 7, 1'b1, 1'b0));
    push_item(make_item(64'hC3, 8, 1'b0, 1'b0));
    push_item(make_item(64'h1, 1, 1'b0, 1'b1));
    // three bits pending plus 64 and a flush: nine bytes from one item
    push_item(make_item(64'h5, 3, 1'b1, 1'b0));
    push_item(make_item(64'hDEAD_BEEF_0BAD_F00D, 64, 1'b1, 1'b1));
    push_item(make_item(64'h2A, 6, 1'b0, 1'b0));
    push_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, 64, 1'b0, 1'b1));
    push_item(make_item(64'h1, 1, 1'b1, 1'b0));
    push_item(make_item(64'h0, 64, 1'b0, 1'b1));
    wait_drained();

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2) wait_drained();
      push_item(rand_field());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bsp_pkg.sv
sv/bsp_in_if.sv
sv/bsp_out_if.sv
sv/bsp_datapath.sv
sv/bsp_ctrl.sv
sv/bit_stream_packer_top.sv
tb/sv/bit_stream_packer_checker.sv
tb/sv/bit_stream_packer_top_tb.sv
